/* rtl/i2cmra_pkg.sv */
// Shared types and codes for the I2C master register access unit.
// No dependencies; imported by the top level and the bench.
package i2cmra_pkg;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'd0,
      PH_START_A = 5'd1,
      PH_START_B = 5'd2,
      PH_BIT_LO  = 5'd3,
      PH_BIT_HI  = 5'd4,
      PH_ACK_LO  = 5'd5,
      PH_ACK_HI  = 5'd6,
      PH_RS_LO   = 5'd7,
      PH_RX_LO   = 5'd8,
      PH_RX_HI   = 5'd9,
      PH_NACK_LO = 5'd10,
      PH_NACK_HI = 5'd11,
      PH_STOP_A  = 5'd12,
      PH_STOP_B  = 5'd13,
      PH_STOP_C  = 5'd14
   } phase_type;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   localparam logic [1:0] CSR_DEVICE_ADDRESS    = 2'd0;
   localparam logic [1:0] CSR_HALF_PERIOD_TICKS = 2'd1;
   localparam logic [1:0] CSR_ACK_TIMEOUT       = 2'd2;

   localparam logic [7:0] HALF_PERIOD_RESET = 8'd2;
   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;

endpackage

/* rtl/i2c_master_register_access_unit.sv */
// Top level of the I2C master register access unit: bus sequencer and result register.
// Depends on i2cmra_pkg.
//
// Each request beat is one bus timing tick: it carries the sampled SDA level and,
// while the unit is idle, an optional write or read command. Each request beat
// gives exactly one response beat with the SCL and SDA drive levels for that tick,
// busy, a done pulse with the ACK error flag, and the byte of the last completed
// read. The sequencer state advances once per beat, so one beat is taken every cycle
// unless stalled; the response register decouples the two sides and a request is
// stalled only while a response is held by rsp_stall. Bus timing follows
// half_period_ticks beats per SCL half period; configuration is written through the
// csr_ port, and the user must do so only while no transaction runs (not enforced).
module i2c_master_register_access_unit
   import i2cmra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_en,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_operation,
   input  logic [7:0] req_target_reg,
   input  logic [7:0] req_write_data,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda_low,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic       rsp_ack_error,
   output logic [7:0] rsp_read_data
);

   // configuration
   logic [6:0] dev_addr_ff;
   logic [7:0] half_period_ff;
   logic [7:0] ack_timeout_ff;

   // sequencer state
   phase_type  phase_ff, phase_in;
   logic [3:0] bit_count_ff, bit_count_in;
   logic [1:0] byte_index_ff, byte_index_in;
   logic [7:0] shift_ff, shift_in;
   logic [7:0] tick_ff, tick_in;
   logic [7:0] ack_wait_ff, ack_wait_in;
   logic [7:0] rx_byte_ff, rx_byte_in;
   logic       is_read_ff, is_read_in;
   logic [7:0] target_reg_ff, target_reg_in;
   logic [7:0] write_data_ff, write_data_in;
   logic       err_ff, err_in;

   // state after command capture
   logic       start_cmd;
   phase_type  phase_c;
   logic [3:0] bit_count_c;
   logic [1:0] byte_index_c;
   logic [7:0] tick_c;
   logic [7:0] ack_wait_c;
   logic       is_read_c;
   logic [7:0] target_reg_c;
   logic [7:0] write_data_c;
   logic       err_c;

   logic [7:0] half_eff;
   logic       seg_end;
   logic [7:0] load_val;
   logic [7:0] rx_shift;

   logic       scl_out, sda_low_out, busy_out, done_out, aerr_out;

   // response register
   logic       rsp_valid_ff;
   logic       scl_ff, sda_low_ff, busy_ff, done_ff, aerr_ff;
   logic [7:0] read_data_ff;

   logic       req_accept;

   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   // command capture, only taken when idle
   always_comb begin
      start_cmd = (phase_ff == PH_IDLE) &&
                  ((req_operation == OP_WRITE) || (req_operation == OP_READ));
      phase_c      = phase_ff;
      bit_count_c  = bit_count_ff;
      byte_index_c = byte_index_ff;
      tick_c       = tick_ff;
      ack_wait_c   = ack_wait_ff;
      is_read_c    = is_read_ff;
      target_reg_c = target_reg_ff;
      write_data_c = write_data_ff;
      err_c        = err_ff;
      if (start_cmd) begin
         phase_c      = PH_START_A;
         bit_count_c  = 4'd0;
         byte_index_c = 2'd0;
         tick_c       = 8'd0;
         ack_wait_c   = 8'd0;
         is_read_c    = (req_operation == OP_READ);
         target_reg_c = req_target_reg;
         write_data_c = req_write_data;
         err_c        = 1'b0;
      end
   end

   assign half_eff = (half_period_ff == 8'd0) ? 8'd1 : half_period_ff;
   assign seg_end  = ({1'b0, tick_c} + 9'd1) >= {1'b0, half_eff};
   assign rx_shift = {shift_ff[6:0], req_sda_in};

   // byte to send for the current byte slot
   always_comb begin
      case (byte_index_c)
         2'd0:    load_val = {dev_addr_ff, 1'b0};
         2'd1:    load_val = target_reg_c;
         default: load_val = is_read_c ? {dev_addr_ff, 1'b1} : write_data_c;
      endcase
   end

   // line levels for this tick
   always_comb begin
      busy_out = (phase_c != PH_IDLE);
      case (phase_c)
         PH_IDLE, PH_START_A, PH_ACK_HI, PH_RX_HI, PH_NACK_HI, PH_STOP_C: begin
            scl_out     = 1'b1;
            sda_low_out = 1'b0;
         end
         PH_START_B, PH_STOP_B: begin
            scl_out     = 1'b1;
            sda_low_out = 1'b1;
         end
         PH_BIT_LO: begin
            scl_out     = 1'b0;
            sda_low_out = ~shift_ff[7];
         end
         PH_BIT_HI: begin
            scl_out     = 1'b1;
            sda_low_out = ~shift_ff[7];
         end
         PH_STOP_A: begin
            scl_out     = 1'b0;
            sda_low_out = 1'b1;
         end
         default: begin
            scl_out     = 1'b0;
            sda_low_out = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      phase_in      = phase_c;
      bit_count_in  = bit_count_c;
      byte_index_in = byte_index_c;
      shift_in      = shift_ff;
      tick_in       = tick_c;
      ack_wait_in   = ack_wait_c;
      rx_byte_in    = rx_byte_ff;
      is_read_in    = is_read_c;
      target_reg_in = target_reg_c;
      write_data_in = write_data_c;
      err_in        = err_c;
      done_out      = 1'b0;
      aerr_out      = 1'b0;
      if ((phase_c != PH_IDLE) && (phase_c != PH_ACK_HI) && !seg_end) begin
         tick_in = tick_c + 8'd1;
      end else begin
         tick_in = 8'd0;
         case (phase_c)
            PH_START_A: phase_in = PH_START_B;
            PH_START_B: begin
               shift_in     = load_val;
               bit_count_in = 4'd0;
               phase_in     = PH_BIT_LO;
            end
            PH_BIT_LO: phase_in = PH_BIT_HI;
            PH_BIT_HI: begin
               shift_in     = {shift_ff[6:0], 1'b0};
               bit_count_in = bit_count_c + 4'd1;
               if (bit_count_c + 4'd1 >= 4'd8) begin
                  ack_wait_in = 8'd0;
                  phase_in    = PH_ACK_LO;
               end else begin
                  phase_in = PH_BIT_LO;
               end
            end
            PH_ACK_LO: phase_in = PH_ACK_HI;
            PH_ACK_HI: begin
               if (!seg_end) begin
                  tick_in = tick_c + 8'd1;
               end else if (!req_sda_in) begin
                  // acknowledged: next byte, repeated start, receive or stop
                  if (!is_read_c && byte_index_c == 2'd2) begin
                     phase_in = PH_STOP_A;
                  end else if (is_read_c && byte_index_c == 2'd1) begin
                     byte_index_in = 2'd2;
                     phase_in      = PH_RS_LO;
                  end else if (is_read_c && byte_index_c != 2'd0) begin
                     bit_count_in = 4'd0;
                     shift_in     = 8'd0;
                     phase_in     = PH_RX_LO;
                  end else begin
                     byte_index_in = byte_index_c + 2'd1;
                     bit_count_in  = 4'd0;
                     case (byte_index_c + 2'd1)
                        2'd1:    shift_in = target_reg_c;
                        default: shift_in = write_data_c;
                     endcase
                     phase_in = PH_BIT_LO;
                  end
               end else if (ack_wait_c >= ack_timeout_ff) begin
                  err_in   = 1'b1;
                  phase_in = PH_STOP_A;
               end else begin
                  ack_wait_in = ack_wait_c + 8'd1;
                  tick_in     = tick_c;
               end
            end
            PH_RS_LO: phase_in = PH_START_A;
            PH_RX_LO: phase_in = PH_RX_HI;
            PH_RX_HI: begin
               shift_in     = rx_shift;
               bit_count_in = bit_count_c + 4'd1;
               if (bit_count_c + 4'd1 >= 4'd8) begin
                  rx_byte_in = rx_shift;
                  phase_in   = PH_NACK_LO;
               end else begin
                  phase_in = PH_RX_LO;
               end
            end
            PH_NACK_LO: phase_in = PH_NACK_HI;
            PH_NACK_HI: phase_in = PH_STOP_A;
            PH_STOP_A:  phase_in = PH_STOP_B;
            PH_STOP_B:  phase_in = PH_STOP_C;
            PH_STOP_C: begin
               done_out = 1'b1;
               aerr_out = err_c;
               err_in   = 1'b0;
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= 7'd0;
         half_period_ff <= HALF_PERIOD_RESET;
         ack_timeout_ff <= ACK_TIMEOUT_RESET;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_DEVICE_ADDRESS:    dev_addr_ff    <= csr_data[6:0];
            CSR_HALF_PERIOD_TICKS: half_period_ff <= csr_data;
            CSR_ACK_TIMEOUT:       ack_timeout_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= 4'd0;
         byte_index_ff <= 2'd0;
         shift_ff      <= 8'd0;
         tick_ff       <= 8'd0;
         ack_wait_ff   <= 8'd0;
         rx_byte_ff    <= 8'd0;
         is_read_ff    <= 1'b0;
         target_reg_ff <= 8'd0;
         write_data_ff <= 8'd0;
         err_ff        <= 1'b0;
      end else if (req_accept) begin
         phase_ff      <= phase_in;
         bit_count_ff  <= bit_count_in;
         byte_index_ff <= byte_index_in;
         shift_ff      <= shift_in;
         tick_ff       <= tick_in;
         ack_wait_ff   <= ack_wait_in;
         rx_byte_ff    <= rx_byte_in;
         is_read_ff    <= is_read_in;
         target_reg_ff <= target_reg_in;
         write_data_ff <= write_data_in;
         err_ff        <= err_in;
      end
   end

   // response register: load on accept, drop valid once the beat is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         scl_ff       <= scl_out;
         sda_low_ff   <= sda_low_out;
         busy_ff      <= busy_out;
         done_ff      <= done_out;
         aerr_ff      <= aerr_out;
         read_data_ff <= rx_byte_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl       = scl_ff;
   assign rsp_sda_low   = sda_low_ff;
   assign rsp_busy_res  = busy_ff;
   assign rsp_done_res  = done_ff;
   assign rsp_ack_error = aerr_ff;
   assign rsp_read_data = read_data_ff;

endmodule

/* rtl/i2cmra_checker.sv */
// Port-level checks for the I2C master register access unit, bound to the top level.
// Depends on i2c_master_register_access_unit.
module i2cmra_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_scl,
   input logic       rsp_sda_low,
   input logic       rsp_busy_res,
   input logic       rsp_done_res,
   input logic       rsp_ack_error,
   input logic [7:0] rsp_read_data
);

   // a held beat keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_read_data) && $stable(rsp_scl)
         && $stable(rsp_sda_low) && $stable(rsp_done_res))
      else $error("response beat changed while stalled");

   // done marks the last tick of a transaction, after the stop condition
   a_done_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> rsp_busy_res && rsp_scl && !rsp_sda_low)
      else $error("done outside the stop condition");

   // error is only flagged together with done
   a_err_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ack_error |-> rsp_done_res)
      else $error("ack error without done");

   // an idle bus is released
   a_idle_lines: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_busy_res |-> rsp_scl && !rsp_sda_low)
      else $error("bus driven while idle");

endmodule

bind i2c_master_register_access_unit i2cmra_checker u_i2cmra_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_scl       (rsp_scl),
   .rsp_sda_low   (rsp_sda_low),
   .rsp_busy_res  (rsp_busy_res),
   .rsp_done_res  (rsp_done_res),
   .rsp_ack_error (rsp_ack_error),
   .rsp_read_data (rsp_read_data)
);

/* bench/tb.sv */
// Self-checking bench for the I2C master register access unit: clocked driver and monitor,
// a cycle-true bus sequencer predictor and random timing on both channels.
// Depends on i2cmra_pkg and i2c_master_register_access_unit.
`timescale 1ns / 1ps

module tb
   import i2cmra_pkg::*;
();

   localparam logic [1:0] OP_SPARE    = 2'd3;  // decodes as a plain tick
   localparam logic [1:0] CSR_SPARE   = 2'd3;  // unused register index
   localparam logic [1:0] NO_REFUSAL  = 2'd3;  // never matches a byte index
   localparam int         QUIET_LIMIT = 3000;
   localparam int         HOLD_CYCLES = 400;
   localparam int         RANDOM_TICKS = 600;

   typedef struct {
      phase_type  phase;
      logic [3:0] bit_count;
      logic [1:0] byte_index;
      logic [7:0] shift_reg;
      logic [7:0] tick_count;
      logic [7:0] ack_wait_count;
      logic [7:0] rx_byte;
      logic       is_read;
      logic [7:0] held_target_reg;
      logic [7:0] held_write_data;
      logic       err_flag;
   } bus_state_type;

   typedef struct {
      logic [6:0] device_address;
      logic [7:0] half_period;
      logic [7:0] ack_timeout;
   } bus_cfg_type;

   typedef struct {
      logic [1:0] operation;
      logic [7:0] target_reg;
      logic [7:0] write_data;
      logic       sda_in;
   } tick_item_type;

   typedef struct {
      logic       scl;
      logic       sda_low;
      logic       busy;
      logic       done;
      logic       ack_error;
      logic [7:0] read_data;
   } bus_drive_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       csr_write_en = 1'b0;
   logic [1:0] csr_index = CSR_DEVICE_ADDRESS;
   logic [7:0] csr_data = 8'h00;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_operation = OP_TICK;
   logic [7:0] req_target_reg = 8'h00;
   logic [7:0] req_write_data = 8'h00;
   logic       req_sda_in = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl;
   logic       rsp_sda_low;
   logic       rsp_busy_res;
   logic       rsp_done_res;
   logic       rsp_ack_error;
   logic [7:0] rsp_read_data;

   i2c_master_register_access_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_target_reg (req_target_reg),
      .req_write_data (req_write_data),
      .req_sda_in     (req_sda_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_scl        (rsp_scl),
      .rsp_sda_low    (rsp_sda_low),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_ack_error  (rsp_ack_error),
      .rsp_read_data  (rsp_read_data)
   );

   bus_cfg_type   bus_cfg;
   bus_state_type model_state;
   bus_state_type shadow_state;   // runs ahead in the generator to shape SDA
   tick_item_type pending_ticks[$];
   bus_drive_type expected_drives[$];
   tick_item_type cur_tick;
   bus_drive_type next_drive;
   bus_drive_type want_drive;
   int         items_made = 0;
   int         mismatches = 0;
   int         rsp_beats = 0;
   int         send_gap = 0;
   int         stall_left = 0;
   int         hold_left = 0;
   int         quiet_cycles = 0;
   bit         calm = 1'b0;
   bit         hold_wanted = 1'b0;
   bit         hold_taken = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bus_state_type bus_idle_state();
      bus_state_type s;
      s.phase = PH_IDLE;
      s.bit_count = '0;
      s.byte_index = '0;
      s.shift_reg = '0;
      s.tick_count = '0;
      s.ack_wait_count = '0;
      s.rx_byte = '0;
      s.is_read = 1'b0;
      s.held_target_reg = '0;
      s.held_write_data = '0;
      s.err_flag = 1'b0;
      return s;
   endfunction

   function automatic void move_to(inout bus_state_type s, input phase_type p);
      s.phase = p;
      s.tick_count = '0;
   endfunction

   function automatic void load_next_byte(inout bus_state_type s, input bus_cfg_type c);
      case (s.byte_index)
         2'd0: s.shift_reg = {c.device_address, 1'b0};
         2'd1: s.shift_reg = s.held_target_reg;
         default: s.shift_reg = s.is_read ? {c.device_address, 1'b1} : s.held_write_data;
      endcase
      s.bit_count = '0;
   endfunction

   // One bus tick: line levels for this tick, then advance the sequencer.
   function automatic void bus_tick(inout bus_state_type s, input bus_cfg_type c,
                                    input tick_item_type it, output bus_drive_type r);
      int   h;
      logic seg_end;
      h = (c.half_period == 8'd0) ? 1 : int'(c.half_period);
      r.scl = 1'b1;
      r.sda_low = 1'b0;
      r.done = 1'b0;
      r.ack_error = 1'b0;
      if (s.phase == PH_IDLE && (it.operation == OP_WRITE || it.operation == OP_READ)) begin
         s.is_read = (it.operation == OP_READ);
         s.held_target_reg = it.target_reg;
         s.held_write_data = it.write_data;
         s.byte_index = '0;
         s.bit_count = '0;
         s.ack_wait_count = '0;
         s.err_flag = 1'b0;
         move_to(s, PH_START_A);
      end
      case (s.phase)
         PH_START_B, PH_STOP_B: r.sda_low = 1'b1;
         PH_BIT_LO: begin
            r.scl = 1'b0;
            r.sda_low = ~s.shift_reg[7];
         end
         PH_BIT_HI: r.sda_low = ~s.shift_reg[7];
         PH_STOP_A: begin
            r.scl = 1'b0;
            r.sda_low = 1'b1;
         end
         PH_ACK_LO, PH_RS_LO, PH_RX_LO, PH_NACK_LO: r.scl = 1'b0;
         default: ;
      endcase
      r.busy = (s.phase != PH_IDLE);
      seg_end = (int'(s.tick_count) + 1 >= h);
      if (s.phase != PH_IDLE && s.phase != PH_ACK_HI && !seg_end) begin
         s.tick_count = s.tick_count + 8'd1;
      end else begin
         case (s.phase)
            PH_START_A: move_to(s, PH_START_B);
            PH_START_B: begin
               load_next_byte(s, c);
               move_to(s, PH_BIT_LO);
            end
            PH_BIT_LO: move_to(s, PH_BIT_HI);
            PH_BIT_HI: begin
               s.shift_reg = {s.shift_reg[6:0], 1'b0};
               s.bit_count = s.bit_count + 4'd1;
               if (s.bit_count >= 4'd8) begin
                  s.ack_wait_count = '0;
                  move_to(s, PH_ACK_LO);
               end else begin
                  move_to(s, PH_BIT_LO);
               end
            end
            PH_ACK_LO: move_to(s, PH_ACK_HI);
            PH_ACK_HI: begin
               if (!seg_end) begin
                  s.tick_count = s.tick_count + 8'd1;
               end else if (!it.sda_in) begin
                  // acked: next byte, repeated start, receive or stop
                  if (!s.is_read) begin
                     if (s.byte_index < 2'd2) begin
                        s.byte_index = s.byte_index + 2'd1;
                        load_next_byte(s, c);
                        move_to(s, PH_BIT_LO);
                     end else begin
                        move_to(s, PH_STOP_A);
                     end
                  end else if (s.byte_index == 2'd0) begin
                     s.byte_index = 2'd1;
                     load_next_byte(s, c);
                     move_to(s, PH_BIT_LO);
                  end else if (s.byte_index == 2'd1) begin
                     s.byte_index = 2'd2;
                     move_to(s, PH_RS_LO);
                  end else begin
                     s.bit_count = '0;
                     s.shift_reg = '0;
                     move_to(s, PH_RX_LO);
                  end
               end else if (s.ack_wait_count >= c.ack_timeout) begin
                  s.err_flag = 1'b1;
                  move_to(s, PH_STOP_A);
               end else begin
                  s.ack_wait_count = s.ack_wait_count + 8'd1;
               end
            end
            PH_RS_LO: move_to(s, PH_START_A);
            PH_RX_LO: move_to(s, PH_RX_HI);
            PH_RX_HI: begin
               s.shift_reg = {s.shift_reg[6:0], it.sda_in};
               s.bit_count = s.bit_count + 4'd1;
               if (s.bit_count >= 4'd8) begin
                  s.rx_byte = s.shift_reg;
                  move_to(s, PH_NACK_LO);
               end else begin
                  move_to(s, PH_RX_LO);
               end
            end
            PH_NACK_LO: move_to(s, PH_NACK_HI);
            PH_NACK_HI: move_to(s, PH_STOP_A);
            PH_STOP_A: move_to(s, PH_STOP_B);
            PH_STOP_B: move_to(s, PH_STOP_C);
            PH_STOP_C: begin
               r.done = 1'b1;
               r.ack_error = s.err_flag;
               s.err_flag = 1'b0;
               move_to(s, PH_IDLE);
            end
            default: move_to(s, PH_IDLE);
         endcase
      end
      r.read_data = s.rx_byte;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      $display("%0t ERROR rsp beat %0d: %s", $time, rsp_beats, msg);
   endtask

   task automatic check_field(input string field, input int got, input int want);
      if (got != want)
         report_mismatch($sformatf("%s is %0h, expected %0h", field, got, want));
   endtask

   // Generator side: queue a tick and advance the look-ahead copy.
   task automatic add_tick(input tick_item_type it);
      bus_drive_type unused;
      bus_tick(shadow_state, bus_cfg, it, unused);
      pending_ticks.push_back(it);
      items_made++;
   endtask

   task automatic idle_ticks(input int n);
      tick_item_type it;
      repeat (n) begin
         it.operation = $urandom_range(0, 1) ? OP_TICK : OP_SPARE;
         it.target_reg = 8'($urandom);
         it.write_data = 8'($urandom);
         it.sda_in = 1'($urandom);
         add_tick(it);
      end
   endtask

   // One register access; the ACK of byte refuse_at is held off until timeout.
   task automatic run_transfer(input logic [1:0] op, input logic [7:0] target_reg,
                               input logic [7:0] data, input logic [1:0] refuse_at);
      tick_item_type it;
      it.operation = op;
      it.target_reg = target_reg;
      it.write_data = data;
      it.sda_in = 1'($urandom);
      add_tick(it);
      while (shadow_state.phase != PH_IDLE) begin
         it.operation = OP_TICK;
         it.target_reg = 8'($urandom);
         it.write_data = 8'($urandom);
         it.sda_in = 1'($urandom);
         // commands while busy must be dropped
         if ($urandom_range(0, 19) == 0)
            it.operation = 2'($urandom_range(1, 3));
         if (shadow_state.phase == PH_ACK_HI) begin
            if (shadow_state.byte_index == refuse_at)
               it.sda_in = 1'b1;
            else if (shadow_state.ack_wait_count >= bus_cfg.ack_timeout ||
                     $urandom_range(0, 3) != 0)
               it.sda_in = 1'b0;
         end
         add_tick(it);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_config(input logic [7:0] addr, input logic [7:0] half,
                             input logic [7:0] timeout);
      csr_write(CSR_DEVICE_ADDRESS, addr);
      csr_write(CSR_HALF_PERIOD_TICKS, half);
      csr_write(CSR_ACK_TIMEOUT, timeout);
      bus_cfg.device_address = addr[6:0];
      bus_cfg.half_period = half;
      bus_cfg.ack_timeout = timeout;
      repeat (2) @(posedge clock);
   endtask

   task automatic drain();
      while (pending_ticks.size() != 0 || req_valid || expected_drives.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [1:0] pick_refusal();
      return ($urandom_range(0, 3) == 0) ? 2'($urandom_range(0, 2)) : NO_REFUSAL;
   endfunction

   // Driver: predict on each accepted beat, then load the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            bus_tick(model_state, bus_cfg, cur_tick, next_drive);
            expected_drives.push_back(next_drive);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
               cur_tick = pending_ticks.pop_front();
               req_valid <= 1'b1;
               req_operation <= cur_tick.operation;
               req_target_reg <= cur_tick.target_reg;
               req_write_data <= cur_tick.write_data;
               req_sda_in <= cur_tick.sda_in;
               if (!calm && $urandom_range(0, 15) == 0)
                  send_gap <= $urandom_range(1, 16);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each accepted beat, then decide the next stall.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_drives.size() == 0) begin
               report_mismatch("beat with nothing expected");
            end else begin
               want_drive = expected_drives.pop_front();
               check_field("scl", rsp_scl, want_drive.scl);
               check_field("sda_low", rsp_sda_low, want_drive.sda_low);
               check_field("busy_res", rsp_busy_res, want_drive.busy);
               check_field("done_res", rsp_done_res, want_drive.done);
               check_field("ack_error", rsp_ack_error, want_drive.ack_error);
               check_field("read_data", rsp_read_data, want_drive.read_data);
            end
            rsp_beats++;
         end
         if (hold_wanted && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_stall <= 1'b1;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_stall <= (hold_left > 1);
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= (stall_left > 1);
         end else if (!calm && $urandom_range(0, 11) == 0) begin
            stall_left <= $urandom_range(1, 16);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog: no beat on either side for too long ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("i2c_master_register_access_unit test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int phase_end;
      int random_end;
      int round;
      bus_cfg.device_address = 7'd0;
      bus_cfg.half_period = HALF_PERIOD_RESET;
      bus_cfg.ack_timeout = ACK_TIMEOUT_RESET;
      model_state = bus_idle_state();
      shadow_state = bus_idle_state();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset settings, first ACK never comes
      idle_ticks(2);
      run_transfer(OP_WRITE, 8'hFF, 8'hFF, 2'd0);
      drain();

      // Directed: all-ones address, single-tick half period, zero timeout
      csr_write(CSR_SPARE, 8'($urandom));
      set_config(8'hFF, 8'd1, 8'd0);
      run_transfer(OP_WRITE, 8'hFF, 8'h00, NO_REFUSAL);
      idle_ticks(2);
      run_transfer(OP_READ, 8'h00, 8'hFF, NO_REFUSAL);
      run_transfer(OP_WRITE, 8'h5A, 8'hA5, 2'd2);
      run_transfer(OP_READ, 8'h80, 8'h00, 2'd1);
      run_transfer(OP_READ, 8'h01, 8'h7F, 2'd2);
      drain();

      // Directed: half period of zero counts as one
      set_config(8'h00, 8'd0, 8'd3);
      run_transfer(OP_READ, 8'h3C, 8'hC3, NO_REFUSAL);
      run_transfer(OP_WRITE, 8'hC3, 8'h3C, 2'd1);
      idle_ticks(3);
      drain();

      random_end = items_made + RANDOM_TICKS;
      round = 0;
      while (items_made < random_end) begin
         set_config(8'($urandom),
                    ($urandom_range(0, 4) != 0) ? 8'($urandom_range(1, 4))
                                                : 8'($urandom_range(5, 20)),
                    ($urandom_range(0, 2) != 0) ? 8'($urandom_range(0, 6))
                                                : 8'($urandom));
         // one round runs against a long receiver hold-off
         if (round == 0)
            hold_wanted = 1'b1;
         phase_end = items_made + 200;
         while (items_made < phase_end) begin
            idle_ticks($urandom_range(0, 4));
            run_transfer($urandom_range(0, 1) ? OP_WRITE : OP_READ, 8'($urandom),
                         8'($urandom), pick_refusal());
         end
         drain();
         round++;
      end

      // Longest ACK timeout, no idling on either side
      calm = 1'b1;
      set_config(8'($urandom), 8'd1, 8'd255);
      run_transfer(OP_WRITE, 8'($urandom), 8'($urandom), 2'd0);
      idle_ticks(4);
      drain();
      repeat (4) @(posedge clock);

      if (mismatches == 0) begin
         $display("i2c_master_register_access_unit test passed");
      end else begin
         $display("i2c_master_register_access_unit test failed");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/i2cmra_pkg.sv
rtl/i2c_master_register_access_unit.sv
rtl/i2cmra_checker.sv
bench/tb.sv
